### src/sli_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sli_pkg;

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_DELETE  = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_INVALID = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_BADOP = 2'd2
    } t_status;

    localparam int unsigned COUNT_W = 8;

    typedef struct packed {
        t_status              status;
        logic                 found;
        logic [COUNT_W-1:0]   count;
    } t_result;

endpackage

`default_nettype wire

### src/sorted_list_insert_delete_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake                 Payload
// input     i_in_valid / o_in_stall   i_operation, i_value
// output    o_out_valid / i_out_stall o_status, o_found, o_count
//
// Add walks down from the top over each entry above the insertion point, and
// writes the code at the front when it lands there; delete walks every valid
// entry; clear, a full add and an unknown operation go straight to the result.
// The walk over the single-port-read entry RAM makes one read and one compare per entry.
// Reset empties the list at once; the RAM contents are not cleared.
// A finished result waits in the output register while the next item is
// taken; the sequencer holds its next result until that register frees up.

module sorted_list_insert_delete_core #(
    parameter int CAPACITY = 128
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [1:0]           i_operation,
    input  wire logic signed [31:0]   i_value,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [1:0]                o_status,
    output logic                      o_found,
    output logic [7:0]                o_count
);

    import sli_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic                res_valid;
    logic                res_ack;
    t_result             res;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic signed [31:0]  mem_wdata;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;
    logic signed [31:0]  mem_rdata;
    logic                r_out_valid;
    t_result             r_out;

    sli_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_operation (i_operation),
        .i_value     (i_value),
        .o_res_valid (res_valid),
        .i_res_ack   (res_ack),
        .o_res       (res),
        .o_we        (mem_we),
        .o_waddr     (mem_waddr),
        .o_wdata     (mem_wdata),
        .o_re        (mem_re),
        .o_raddr     (mem_raddr),
        .i_rdata     (mem_rdata)
    );

    sli_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign res_ack = res_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ack) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ack) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out.status;
    assign o_found     = r_out.found;
    assign o_count     = r_out.count;

endmodule

`default_nettype wire

### src/sli_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module sli_ram #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [AW-1:0]        i_waddr,
    input  wire logic signed [31:0]   i_wdata,
    input  wire logic                 i_re,
    input  wire logic [AW-1:0]        i_raddr,
    output logic signed [31:0]        o_rdata
);

    logic signed [31:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### src/sli_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module sli_ctrl #(
    parameter int CAPACITY = 128,
    parameter int AW       = 7,
    parameter int CW       = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [1:0]           i_operation,
    input  wire logic signed [31:0]   i_value,
    output logic                      o_res_valid,
    input  wire logic                 i_res_ack,
    output sli_pkg::t_result          o_res,
    output logic                      o_we,
    output logic [AW-1:0]             o_waddr,
    output logic signed [31:0]        o_wdata,
    output logic                      o_re,
    output logic [AW-1:0]             o_raddr,
    input  wire logic signed [31:0]   i_rdata
);

    import sli_pkg::*;

    localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_RD,
        S_ADD_CMP,
        S_DEL_RD,
        S_DEL_CMP,
        S_DONE
    } t_state;

    t_state             r_state;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_k;
    logic signed [31:0] r_value;
    logic               r_found;
    t_status            r_status;
    logic [CW-1:0]      k_dec;

    assign k_dec = r_k - 1'b1;

    // Memory accesses follow the state: a read is issued in a read state and
    // its data is used in the following compare state.
    always_comb begin
        o_we    = 1'b0;
        o_waddr = '0;
        o_wdata = i_rdata;
        o_re    = 1'b0;
        o_raddr = '0;
        unique case (r_state)
            S_ADD_RD: begin
                if (r_k == '0) begin
                    o_we    = 1'b1;
                    o_wdata = r_value;
                end else begin
                    o_re    = 1'b1;
                    o_raddr = k_dec[AW-1:0];
                end
            end
            S_ADD_CMP: begin
                // Entries greater than the new code move up one place.
                o_we    = 1'b1;
                o_waddr = r_k[AW-1:0];
                o_wdata = (r_value < i_rdata) ? i_rdata : r_value;
            end
            S_DEL_RD: begin
                if (r_k != r_count) begin
                    o_re    = 1'b1;
                    o_raddr = r_k[AW-1:0];
                end
            end
            S_DEL_CMP: begin
                // Past the removed entry, every entry moves down one place.
                if (r_found) begin
                    o_we    = 1'b1;
                    o_waddr = k_dec[AW-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_k      <= '0;
            r_found  <= 1'b0;
            r_status <= ST_OK;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_value  <= i_value;
                        r_found  <= 1'b0;
                        r_status <= ST_OK;
                        unique case (t_op'(i_operation))
                            OP_ADD: begin
                                if (r_count >= CapCount) begin
                                    r_status <= ST_FULL;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_k     <= r_count;
                                    r_state <= S_ADD_RD;
                                end
                            end
                            OP_DELETE: begin
                                r_k     <= '0;
                                r_state <= S_DEL_RD;
                            end
                            OP_CLEAR: begin
                                r_count <= '0;
                                r_state <= S_DONE;
                            end
                            OP_INVALID: begin
                                r_status <= ST_BADOP;
                                r_state  <= S_DONE;
                            end
                            default: begin
                                r_status <= ST_BADOP;
                                r_state  <= S_DONE;
                            end
                        endcase
                    end
                end
                S_ADD_RD: begin
                    if (r_k == '0) begin
                        r_count <= r_count + 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_ADD_CMP;
                    end
                end
                S_ADD_CMP: begin
                    if (r_value < i_rdata) begin
                        r_k     <= k_dec;
                        r_state <= S_ADD_RD;
                    end else begin
                        r_count <= r_count + 1'b1;
                        r_state <= S_DONE;
                    end
                end
                S_DEL_RD: begin
                    if (r_k == r_count) begin
                        if (r_found) begin
                            r_count <= r_count - 1'b1;
                        end
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_DEL_CMP;
                    end
                end
                S_DEL_CMP: begin
                    if (!r_found && (i_rdata == r_value)) begin
                        r_found <= 1'b1;
                    end
                    r_k     <= r_k + 1'b1;
                    r_state <= S_DEL_RD;
                end
                S_DONE: begin
                    if (i_res_ack) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_res_valid  = (r_state == S_DONE);
    assign o_res.status = r_status;
    assign o_res.found  = r_found;
    assign o_res.count  = COUNT_W'(r_count);

endmodule

`default_nettype wire
